// ===== rtl/core/utf16_line_entry_to_utf8_macros.svh =====
// Assertion shorthands for the line-entry block.
// Each check is sampled on the rising clock edge and is off while reset is high.
`ifndef UTF16_LINE_ENTRY_TO_UTF8_MACROS_SVH
`define UTF16_LINE_ENTRY_TO_UTF8_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U16L_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U16L_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/u16l2u8_pkg.sv =====
`default_nettype none

package u16l2u8_pkg;

   localparam int unsigned MAX_BYTES  = 64;
   localparam int unsigned BUF_AW     = $clog2(MAX_BYTES);
   localparam int unsigned LEN_W      = 7;
   localparam int unsigned CP_W       = 21;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      OP_CHAR      = 3'd0,
      OP_KEY_DOWN  = 3'd1,
      OP_KEY_OTHER = 3'd2,
      OP_UNRELATED = 3'd3,
      OP_BEGIN     = 3'd4,
      OP_CANCEL    = 3'd5,
      OP_TAKE      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      OUT_TYPING    = 2'd0,
      OUT_SUBMITTED = 2'd1,
      OUT_CANCELLED = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERASE_RD,
      ST_ERASE_CHK,
      ST_WRITE,
      ST_TAKE_RD,
      ST_TAKE_OUT,
      ST_RESULT
   } state_type;

   localparam logic [15:0]     CU_BACKSPACE = 16'h0008;
   localparam logic [15:0]     CU_ENTER     = 16'h000D;
   localparam logic [15:0]     CU_ESCAPE    = 16'h001B;
   localparam logic [15:0]     CU_SPACE     = 16'h0020;
   localparam logic [7:0]      KEY_ESCAPE   = 8'h1B;
   localparam logic [15:0]     SUR_HIGH     = 16'hD800;
   localparam logic [15:0]     SUR_LOW      = 16'hDC00;
   localparam logic [15:0]     SUR_END      = 16'hDFFF;
   localparam logic [CP_W-1:0] SUPP_BASE    = 21'h10000;
   localparam logic [CP_W-1:0] CP_LIM1      = 21'h00080;
   localparam logic [CP_W-1:0] CP_LIM2      = 21'h00800;
   localparam logic [CP_W-1:0] CP_LIM3      = 21'h10000;
   localparam logic [7:0]      LEAD2        = 8'hC0;
   localparam logic [7:0]      LEAD3        = 8'hE0;
   localparam logic [7:0]      LEAD4        = 8'hF0;
   localparam logic [7:0]      CONT         = 8'h80;
   localparam logic [7:0]      CONT_MASK    = 8'hC0;

endpackage

`default_nettype wire

// ===== rtl/core/u16l2u8_ram.sv =====
`default_nettype none

module u16l2u8_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/utf16_line_entry_to_utf8.sv =====
// Sequence: a plain event goes to the result state, which loads its result; an append first
//   writes each UTF-8 byte (1..4) in turn, a backspace reads each byte erased, then checks it.
// Take after submit: each text byte is read from the buffer, then loaded into the output register.
// One event at a time: the next transfer is taken in the cycle after the last result
//   is loaded; a full output register holds the sequencer.
// Reset: synchronous, active high; clears entry state and output valid, not the text buffer.
`default_nettype none

`include "utf16_line_entry_to_utf8_macros.svh"

module utf16_line_entry_to_utf8 (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input events
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [u16l2u8_pkg::REQ_DATA_W-1:0]  req_tdata,  // code_unit[15:0], key_code[23:16]
   input  wire logic [2:0]                          req_tuser,  // operation[2:0]
   // Results
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [u16l2u8_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // consumed[0], typing_active[1],
                                                                // outcome[3:2], text_length[10:4],
                                                                // text_byte[18:11], zeros above
   output      logic                                rsp_tuser,  // byte_valid
   output      logic                                rsp_tlast
);

   import u16l2u8_pkg::*;

   // Entry state
   state_type              state_ff,       state_in;
   logic                   active_ff,      active_in;
   outcome_type            outcome_ff,     outcome_in;
   logic [15:0]            pending_ff,     pending_in;
   logic [LEN_W-1:0]       len_ff,         len_in;

   // Per-event working registers
   logic                   consumed_ff,    consumed_in;
   outcome_type            res_outcome_ff, res_outcome_in;
   logic [CP_W-1:0]        cp_ff,          cp_in;
   logic [2:0]             nbytes_ff,      nbytes_in;
   logic [1:0]             wr_idx_ff,      wr_idx_in;
   logic [BUF_AW-1:0]      idx_ff,         idx_in;
   logic [LEN_W-1:0]       count_ff,       count_in;

   // Output register
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic                   rsp_bvalid_ff;
   logic                   rsp_last_ff;
   logic                   rsp_load;
   logic [RSP_DATA_W-1:0]  rsp_data_in;
   logic                   rsp_bvalid_in;
   logic                   rsp_last_in;
   logic                   out_free;

   // Text buffer port
   logic                   ram_we;
   logic [BUF_AW-1:0]      ram_wr_addr;
   logic [7:0]             ram_wr_data;
   logic [BUF_AW-1:0]      ram_rd_addr;
   logic [7:0]             ram_rd_data;

   // Event decode
   logic [2:0]             op;
   logic [15:0]            unit;
   logic [7:0]             key;
   logic                   is_high;
   logic                   is_low;
   logic [CP_W-1:0]        joined_cp;
   logic [CP_W-1:0]        sel_cp;
   logic [2:0]             sel_nbytes;
   logic                   room_ok;
   logic                   take_last;

   assign op   = req_tuser;
   assign unit = req_tdata[15:0];
   assign key  = req_tdata[23:16];

   assign is_high   = (unit >= SUR_HIGH) && (unit < SUR_LOW);
   assign is_low    = (unit >= SUR_LOW) && (unit <= SUR_END);
   // Join a surrogate pair: ten bits from each half over the supplementary base.
   assign joined_cp = SUPP_BASE + {1'b0, pending_ff[9:0], unit[9:0]};
   assign sel_cp    = is_low ? joined_cp : {5'b0, unit};
   assign sel_nbytes = (sel_cp < CP_LIM1) ? 3'd1 :
                       (sel_cp < CP_LIM2) ? 3'd2 :
                       (sel_cp < CP_LIM3) ? 3'd3 : 3'd4;
   // Append only while four bytes of room remain.
   assign room_ok   = ({1'b0, len_ff} + 8'd4) <= 8'(MAX_BYTES);
   assign take_last = (LEN_W'(idx_ff) + LEN_W'(1)) == count_ff;

   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Produce byte k of an n-byte UTF-8 sequence for code point cp.
   function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [2:0] n,
                                            input logic [1:0] k);
      logic [1:0] rem;
      logic [7:0] b;
      rem = 2'(n - 3'd1 - {1'b0, k});
      if (k == 2'd0) begin
         case (n)
            3'd1:    b = {1'b0, cp[6:0]};
            3'd2:    b = LEAD2 | {3'b0, cp[10:6]};
            3'd3:    b = LEAD3 | {4'b0, cp[15:12]};
            default: b = LEAD4 | {5'b0, cp[20:18]};
         endcase
      end else begin
         case (rem)
            2'd0:    b = CONT | {2'b0, cp[5:0]};
            2'd1:    b = CONT | {2'b0, cp[11:6]};
            default: b = CONT | {2'b0, cp[17:12]};
         endcase
      end
      return b;
   endfunction

   u16l2u8_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_text_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         outcome_ff   <= OUT_TYPING;
         pending_ff   <= 16'h0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         outcome_ff   <= outcome_in;
         pending_ff   <= pending_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      consumed_ff    <= consumed_in;
      res_outcome_ff <= res_outcome_in;
      cp_ff          <= cp_in;
      nbytes_ff      <= nbytes_in;
      wr_idx_ff      <= wr_idx_in;
      idx_ff         <= idx_in;
      count_ff       <= count_in;
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_bvalid_ff <= rsp_bvalid_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      outcome_in     = outcome_ff;
      pending_in     = pending_ff;
      len_in         = len_ff;
      consumed_in    = consumed_ff;
      res_outcome_in = res_outcome_ff;
      cp_in          = cp_ff;
      nbytes_in      = nbytes_ff;
      wr_idx_in      = wr_idx_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;

      req_tready     = 1'b0;
      ram_we         = 1'b0;
      ram_wr_addr    = len_ff[BUF_AW-1:0];
      ram_wr_data    = utf8_byte(cp_ff, nbytes_ff, wr_idx_ff);
      ram_rd_addr    = idx_ff;

      rsp_load       = 1'b0;
      rsp_data_in    = {5'b0, 8'h00, len_ff, res_outcome_ff, active_ff, consumed_ff};
      rsp_bvalid_in  = 1'b0;
      rsp_last_in    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               consumed_in = 1'b0;
               state_in    = ST_RESULT;
               unique case (op)
                  OP_CHAR: begin
                     if (active_ff) begin
                        consumed_in = 1'b1;
                        if (unit == CU_BACKSPACE) begin
                           if (len_ff != '0) begin
                              state_in = ST_ERASE_RD;
                           end
                        end else if (unit == CU_ENTER) begin
                           active_in  = 1'b0;
                           outcome_in = OUT_SUBMITTED;
                        end else if (unit == CU_ESCAPE) begin
                           active_in  = 1'b0;
                           len_in     = '0;
                           outcome_in = OUT_CANCELLED;
                        end else if (unit >= CU_SPACE) begin
                           if (is_high) begin
                              // Hold the high half; a newer one replaces it.
                              pending_in = unit;
                           end else if (!is_low || pending_ff != 16'h0) begin
                              if (is_low) begin
                                 pending_in = 16'h0;
                              end
                              if (room_ok) begin
                                 cp_in     = sel_cp;
                                 nbytes_in = sel_nbytes;
                                 wr_idx_in = 2'd0;
                                 state_in  = ST_WRITE;
                              end
                           end
                           // A lone low half is dropped.
                        end
                     end
                  end
                  OP_KEY_DOWN: begin
                     if (active_ff) begin
                        consumed_in = 1'b1;
                        if (key == KEY_ESCAPE) begin
                           active_in  = 1'b0;
                           len_in     = '0;
                           outcome_in = OUT_CANCELLED;
                        end
                     end
                  end
                  OP_KEY_OTHER: begin
                     consumed_in = active_ff;
                  end
                  OP_BEGIN: begin
                     active_in  = 1'b1;
                     len_in     = '0;
                     outcome_in = OUT_TYPING;
                     pending_in = 16'h0;
                  end
                  OP_CANCEL: begin
                     active_in  = 1'b0;
                     len_in     = '0;
                     outcome_in = OUT_CANCELLED;
                  end
                  OP_TAKE: begin
                     outcome_in = OUT_TYPING;
                     if (outcome_ff == OUT_SUBMITTED) begin
                        len_in = '0;
                        if (len_ff != '0) begin
                           count_in = len_ff;
                           idx_in   = '0;
                           state_in = ST_TAKE_RD;
                        end
                     end
                  end
                  default: begin
                     // Unrelated messages and the spare code pass through untouched.
                  end
               endcase
               res_outcome_in = (op == OP_TAKE) ? outcome_ff : outcome_in;
            end
         end
         ST_ERASE_RD: begin
            // Step back one byte and fetch it.
            ram_rd_addr = BUF_AW'(len_ff - LEN_W'(1));
            len_in      = len_ff - LEN_W'(1);
            state_in    = ST_ERASE_CHK;
         end
         ST_ERASE_CHK: begin
            // Keep erasing while the byte just removed was a continuation byte.
            if (((ram_rd_data & CONT_MASK) == CONT) && (len_ff != '0)) begin
               state_in = ST_ERASE_RD;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            len_in    = len_ff + LEN_W'(1);
            wr_idx_in = wr_idx_ff + 2'd1;
            if (({1'b0, wr_idx_ff} + 3'd1) == nbytes_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_TAKE_RD: begin
            state_in = ST_TAKE_OUT;
         end
         ST_TAKE_OUT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_data_in   = {5'b0, ram_rd_data, len_ff, OUT_SUBMITTED, active_ff, 1'b0};
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = take_last;
               if (take_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + BUF_AW'(1);
                  state_in = ST_TAKE_RD;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

   `U16L_CHECK_NOW(a_len_bound, 1'b1, len_ff <= LEN_W'(MAX_BYTES), "text length over capacity")
   `U16L_CHECK_NOW(a_pending_high, 1'b1,
      pending_ff == 16'h0 || pending_ff[15:10] == SUR_HIGH[15:10],
      "pending value is not a high surrogate")
   `U16L_CHECK_NOW(a_write_idx, state_ff == ST_WRITE,
      ({1'b0, wr_idx_ff} < nbytes_ff) && (len_ff < LEN_W'(MAX_BYTES)),
      "byte write past sequence or buffer end")
   `U16L_CHECK_NOW(a_byte_rsp, rsp_tvalid && rsp_tuser,
      rsp_tdata[3:2] == OUT_SUBMITTED && rsp_tdata[10:4] == '0,
      "text byte outside a submitted take")
   `U16L_CHECK_NEXT(a_busy_after_accept, req_tvalid && req_tready, state_ff != ST_IDLE,
      "idle right after an input transfer")

endmodule

`default_nettype wire
